@@ hw/rtl/glyph_bitmap_to_rgb565_stream_core_macros.svh @@
// Assertion macros shared by the glyph stream RTL.
`ifndef GLYPH_BITMAP_TO_RGB565_STREAM_CORE_MACROS_SVH
`define GLYPH_BITMAP_TO_RGB565_STREAM_CORE_MACROS_SVH

// Same-cycle implication.
`define GBRS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GBRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/gbrs_pkg.sv @@
// Package: types and constants of the glyph bitmap to RGB565 stream core.
package gbrs_pkg;

   localparam int SIDE_W             = 7;
   localparam int SIDE_LIMIT         = 127;
   localparam int COORD_W            = 16;
   localparam int COLOR_W            = 16;
   localparam int USED_W             = 4;
   localparam int STEP_W             = 4;
   localparam int DEF_MAX_GLYPH_SIDE = 64;
   localparam int DEF_QUEUE_DEPTH    = 4;
   localparam int REQ_DATA_W         = 56;
   localparam int RSP_DATA_W         = 8;
   localparam int RSP_USER_W         = 2;
   localparam int CSR_INDEX_W        = 1;

   localparam logic [7:0] CMD_COLUMN = 8'h2A;
   localparam logic [7:0] CMD_ROW    = 8'h2B;
   localparam logic [7:0] CMD_WRITE  = 8'h2C;

   localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOREGROUND = 1'b0,
      CSR_BACKGROUND = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_START  = 1'b0,
      MODE_BITMAP = 1'b1
   } mode_type;

   typedef enum logic {
      JOB_WINDOW = 1'b0,
      JOB_PIXELS = 1'b1
   } job_kind_type;

   typedef struct packed {
      logic              mode;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [SIDE_W-1:0]  glyph_width;
      logic [SIDE_W-1:0]  glyph_height;
      logic [7:0]         bitmap_byte;
   } req_type;

   typedef struct packed {
      job_kind_type       kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] y_end;
      logic [7:0]         bits;
      logic [USED_W-1:0]  used;
      logic               glyph_done;
   } job_type;

endpackage

@@ hw/rtl/glyph_bitmap_to_rgb565_stream_core.sv @@
// Top level of the glyph bitmap to RGB565 byte stream core.
//
//  channel  | direction | handshake            | payload
//  req_     | in        | req_tvalid/tready    | tdata 56b, tuser mode
//  rsp_     | out       | rsp_tvalid/tready    | tdata byte, tuser flags, tlast
//  csr_     | in        | csr_valid/csr_ready  | index 1b, data 16b
//
// A start item yields 11 bytes, a bitmap byte 2 per used pixel (up to 16),
// one byte per cycle out of the output register while rsp_tready is high.
// The generator loads its next job from a 4-entry queue in the cycle the
// last byte of the current job enters the output register, so jobs run back to back.
// Reset is synchronous; colors return to white foreground, black background.
// req_tready drops only while the job queue is full; csr_ready is always high.
module glyph_bitmap_to_rgb565_stream_core
   import gbrs_pkg::*;
#(
   parameter int MAX_GLYPH_SIDE = DEF_MAX_GLYPH_SIDE,
   parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pos_x, pos_y, glyph_width, glyph_height, bitmap_byte, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_byte
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // is_command, glyph_end
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   req_type            req;
   job_type            push_job, head_job;
   logic               q_push, q_ready, q_pop, q_valid;
   logic [COLOR_W-1:0] fg_ff, bg_ff;

   assign req.mode         = req_tuser[0];
   assign req.pos_x        = req_tdata[15:0];
   assign req.pos_y        = req_tdata[31:16];
   assign req.glyph_width  = req_tdata[38:32];
   assign req.glyph_height = req_tdata[45:39];
   assign req.bitmap_byte  = req_tdata[53:46];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FOREGROUND: fg_ff <= csr_data;
            CSR_BACKGROUND: bg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gbrs_front #(
      .MAX_GLYPH_SIDE(MAX_GLYPH_SIDE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req      (req),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   gbrs_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .push_ready(q_ready),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_job  (head_job)
   );

   gbrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(q_valid),
      .head_job  (head_job),
      .pop       (q_pop),
      .fg_color  (fg_ff),
      .bg_color  (bg_ff),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

@@ hw/rtl/gbrs_front.sv @@
// Front end: accepts items, tracks glyph progress and turns start items, and bitmap items while drawing, into jobs.
module gbrs_front
   import gbrs_pkg::*;
#(
   parameter int MAX_GLYPH_SIDE = DEF_MAX_GLYPH_SIDE
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   input  logic    q_ready,
   output logic    q_push,
   output job_type q_job
);

   localparam int SIDE_CAP   = (MAX_GLYPH_SIDE > SIDE_LIMIT) ? SIDE_LIMIT : MAX_GLYPH_SIDE;
   localparam int ROW_BYTES  = (SIDE_CAP + 7) / 8;
   localparam int BYTE_IDX_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   logic                  drawing_ff, drawing_in;
   logic [SIDE_W-1:0]     cur_width_ff, cur_width_in;
   logic [SIDE_W-1:0]     cur_height_ff, cur_height_in;
   logic [BYTE_IDX_W-1:0] byte_in_row_ff, byte_in_row_in;
   logic [SIDE_W-1:0]     row_count_ff, row_count_in;

   logic                  accept;
   logic [SIDE_W-1:0]     w_cl, h_cl;
   logic [SIDE_W-1:0]     col, rem;
   logic                  row_done, glyph_done;
   logic [USED_W-1:0]     used;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;

   assign w_cl = (int'(req.glyph_width) > MAX_GLYPH_SIDE) ? SIDE_W'(MAX_GLYPH_SIDE)
                                                         : req.glyph_width;
   assign h_cl = (int'(req.glyph_height) > MAX_GLYPH_SIDE) ? SIDE_W'(MAX_GLYPH_SIDE)
                                                          : req.glyph_height;

   assign col        = SIDE_W'({byte_in_row_ff, 3'b000});
   assign rem        = cur_width_ff - col;
   assign row_done   = (rem <= SIDE_W'(8));
   assign used       = row_done ? USED_W'(rem) : USED_W'(8);
   assign glyph_done = row_done &&
                       (({1'b0, row_count_ff} + (SIDE_W + 1)'(1)) >= {1'b0, cur_height_ff});

   always_comb begin
      q_job            = '0;
      q_push           = 1'b0;
      drawing_in       = drawing_ff;
      cur_width_in     = cur_width_ff;
      cur_height_in    = cur_height_ff;
      byte_in_row_in   = byte_in_row_ff;
      row_count_in     = row_count_ff;
      if (accept) begin
         if (req.mode == MODE_START) begin
            q_push         = 1'b1;
            q_job.kind     = JOB_WINDOW;
            q_job.x        = req.pos_x;
            q_job.x_end    = req.pos_x + COORD_W'(w_cl) - COORD_W'(1);
            q_job.y        = req.pos_y;
            q_job.y_end    = req.pos_y + COORD_W'(h_cl) - COORD_W'(1);
            cur_width_in   = w_cl;
            cur_height_in  = h_cl;
            byte_in_row_in = '0;
            row_count_in   = '0;
            drawing_in     = (w_cl != '0) && (h_cl != '0);
         end else if (drawing_ff) begin
            q_push           = 1'b1;
            q_job.kind       = JOB_PIXELS;
            q_job.bits       = req.bitmap_byte;
            q_job.used       = used;
            q_job.glyph_done = glyph_done;
            if (glyph_done) begin
               drawing_in     = 1'b0;
               byte_in_row_in = '0;
               row_count_in   = '0;
            end else if (row_done) begin
               byte_in_row_in = '0;
               row_count_in   = row_count_ff + SIDE_W'(1);
            end else begin
               byte_in_row_in = byte_in_row_ff + BYTE_IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drawing_ff     <= 1'b0;
         cur_width_ff   <= '0;
         cur_height_ff  <= '0;
         byte_in_row_ff <= '0;
         row_count_ff   <= '0;
      end else begin
         drawing_ff     <= drawing_in;
         cur_width_ff   <= cur_width_in;
         cur_height_ff  <= cur_height_in;
         byte_in_row_ff <= byte_in_row_in;
         row_count_ff   <= row_count_in;
      end
   end

endmodule

@@ hw/rtl/gbrs_queue.sv @@
// Job queue between the front end and the byte generator.
`include "glyph_bitmap_to_rgb565_stream_core_macros.svh"
module gbrs_queue
   import gbrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push_ready = !full;
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `GBRS_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `GBRS_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, head_valid, "pop from empty queue")
   `GBRS_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "count did not grow")
   `GBRS_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - CNT_W'(1), "count did not shrink")

endmodule

@@ hw/rtl/gbrs_back.sv @@
// Back end: expands jobs into window command bytes and RGB565 pixel bytes.
`include "glyph_bitmap_to_rgb565_stream_core_macros.svh"
module gbrs_back
   import gbrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  job_type               head_job,
   output logic                  pop,
   input  logic [COLOR_W-1:0]    fg_color,
   input  logic [COLOR_W-1:0]    bg_color,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam logic [STEP_W-1:0] WS_COL_CMD = 4'd0;
   localparam logic [STEP_W-1:0] WS_X_HI    = 4'd1;
   localparam logic [STEP_W-1:0] WS_X_LO    = 4'd2;
   localparam logic [STEP_W-1:0] WS_XE_HI   = 4'd3;
   localparam logic [STEP_W-1:0] WS_XE_LO   = 4'd4;
   localparam logic [STEP_W-1:0] WS_ROW_CMD = 4'd5;
   localparam logic [STEP_W-1:0] WS_Y_HI    = 4'd6;
   localparam logic [STEP_W-1:0] WS_Y_LO    = 4'd7;
   localparam logic [STEP_W-1:0] WS_YE_HI   = 4'd8;
   localparam logic [STEP_W-1:0] WS_YE_LO   = 4'd9;
   localparam logic [STEP_W-1:0] WS_WR_CMD  = 4'd10;

   job_type             cur_ff, cur_in;
   logic                active_ff, active_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                cmd_ff, cmd_in;
   logic                end_ff, end_in;
   logic                last_ff, last_in;

   logic                advance, emit, load;
   logic [7:0]          gen_byte;
   logic                gen_cmd, gen_last;
   logic [COLOR_W-1:0]  color;
   logic [STEP_W-1:0]   pix_last;

   assign advance  = !valid_ff || rsp_tready;
   assign emit     = active_ff && advance;
   assign color    = cur_ff.bits[step_ff[STEP_W-1:1]] ? fg_color : bg_color;
   assign pix_last = STEP_W'({cur_ff.used, 1'b0} - (USED_W + 1)'(1));

   always_comb begin
      gen_byte = '0;
      gen_cmd  = 1'b0;
      gen_last = 1'b0;
      if (cur_ff.kind == JOB_WINDOW) begin
         gen_last = (step_ff == WS_WR_CMD);
         unique case (step_ff)
            WS_COL_CMD: begin gen_byte = CMD_COLUMN;        gen_cmd = 1'b1; end
            WS_X_HI:    gen_byte = cur_ff.x[15:8];
            WS_X_LO:    gen_byte = cur_ff.x[7:0];
            WS_XE_HI:   gen_byte = cur_ff.x_end[15:8];
            WS_XE_LO:   gen_byte = cur_ff.x_end[7:0];
            WS_ROW_CMD: begin gen_byte = CMD_ROW;           gen_cmd = 1'b1; end
            WS_Y_HI:    gen_byte = cur_ff.y[15:8];
            WS_Y_LO:    gen_byte = cur_ff.y[7:0];
            WS_YE_HI:   gen_byte = cur_ff.y_end[15:8];
            WS_YE_LO:   gen_byte = cur_ff.y_end[7:0];
            WS_WR_CMD:  begin gen_byte = CMD_WRITE;         gen_cmd = 1'b1; end
            default:    gen_byte = '0;
         endcase
      end else begin
         gen_byte = step_ff[0] ? color[7:0] : color[15:8];
         gen_last = (step_ff == pix_last);
      end
   end

   assign load = head_valid && (!active_ff || (emit && gen_last));
   assign pop  = load;

   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      step_in   = step_ff;
      if (load) begin
         cur_in    = head_job;
         active_in = 1'b1;
         step_in   = '0;
      end else if (emit) begin
         active_in = !gen_last;
         step_in   = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      cmd_in   = cmd_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = emit;
         byte_in  = gen_byte;
         cmd_in   = gen_cmd;
         end_in   = gen_last && (cur_ff.kind == JOB_PIXELS) && cur_ff.glyph_done;
         last_in  = gen_last;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      byte_ff <= byte_in;
      cmd_ff  <= cmd_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {end_ff, cmd_ff};
   assign rsp_tlast  = last_ff;

   `GBRS_ASSERT_IMPLIES(a_end_is_last_data, clock, reset, valid_ff && end_ff, last_ff && !cmd_ff, "glyph end off a final pixel byte")
   `GBRS_ASSERT_IMPLIES(a_cmd_code, clock, reset, valid_ff && cmd_ff, byte_ff == CMD_COLUMN || byte_ff == CMD_ROW || byte_ff == CMD_WRITE, "bad command byte")
   `GBRS_ASSERT_IMPLIES(a_window_step, clock, reset, active_ff && cur_ff.kind == JOB_WINDOW, step_ff <= WS_WR_CMD, "window step out of range")

endmodule

@@ test/glyph_stream_checker.sv @@
// Checker: predicts the panel byte stream of the glyph core and compares every output item.
module glyph_stream_checker
   import gbrs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [0:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [RSP_USER_W-1:0]  rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data,
   output int                     mismatches,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] value;
      logic       is_command;
      logic       glyph_end;
      logic       last_of_run;
   } link_byte_type;

   link_byte_type      link_bytes[$];
   logic [COLOR_W-1:0] fg_color;
   logic [COLOR_W-1:0] bg_color;
   logic               drawing;
   logic [SIDE_W-1:0]  cur_width;
   logic [SIDE_W-1:0]  cur_height;
   logic [2:0]         byte_col;
   logic [SIDE_W-1:0]  row_cnt;
   int                 fail_count = 0;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] side);
      return (side > DEF_MAX_GLYPH_SIDE) ? SIDE_W'(DEF_MAX_GLYPH_SIDE) : side;
   endfunction

   task automatic add_byte(input logic [7:0] value, input logic cmd, input logic gend);
      link_byte_type b;
      b.value       = value;
      b.is_command  = cmd;
      b.glyph_end   = gend;
      b.last_of_run = 1'b0;
      link_bytes.push_back(b);
   endtask

   task automatic add_window(input logic [7:0] cmd, input logic [COORD_W-1:0] first,
                             input logic [SIDE_W-1:0] len);
      logic [COORD_W-1:0] last;
      last = first + COORD_W'(len) - 16'd1;
      add_byte(cmd, 1'b1, 1'b0);
      add_byte(first[15:8], 1'b0, 1'b0);
      add_byte(first[7:0], 1'b0, 1'b0);
      add_byte(last[15:8], 1'b0, 1'b0);
      add_byte(last[7:0], 1'b0, 1'b0);
   endtask

   task automatic expand_glyph_item(input logic mode, input logic [REQ_DATA_W-1:0] data);
      int                 queued;
      int                 col;
      int                 used;
      bit                 row_done;
      bit                 glyph_done;
      logic [COLOR_W-1:0] color;
      logic [7:0]         bits;
      logic [SIDE_W-1:0]  w;
      logic [SIDE_W-1:0]  h;
      queued = link_bytes.size();
      if (mode_type'(mode) == MODE_START) begin
         w = clamp_side(data[38:32]);
         h = clamp_side(data[45:39]);
         add_window(CMD_COLUMN, data[15:0], w);
         add_window(CMD_ROW, data[31:16], h);
         add_byte(CMD_WRITE, 1'b1, 1'b0);
         cur_width  = w;
         cur_height = h;
         byte_col   = '0;
         row_cnt    = '0;
         drawing    = (w != 0) && (h != 0);
      end else if (drawing) begin
         bits = data[53:46];
         col  = int'(byte_col) * 8;
         used = int'(cur_width) - col;
         if (used > 8)
            used = 8;
         row_done   = (col + used >= int'(cur_width));
         glyph_done = row_done && (int'(row_cnt) + 1 >= int'(cur_height));
         for (int i = 0; i < used; i++) begin
            color = bits[i] ? fg_color : bg_color;
            add_byte(color[15:8], 1'b0, 1'b0);
            add_byte(color[7:0], 1'b0, glyph_done && (i == used - 1));
         end
         if (glyph_done) begin
            drawing  = 1'b0;
            byte_col = '0;
            row_cnt  = '0;
         end else if (row_done) begin
            byte_col = '0;
            row_cnt  = row_cnt + 1'b1;
         end else begin
            byte_col = byte_col + 1'b1;
         end
      end
      if (link_bytes.size() > queued)
         link_bytes[link_bytes.size() - 1].last_of_run = 1'b1;
   endtask

   task automatic check_link_byte();
      link_byte_type e;
      if (link_bytes.size() == 0) begin
         $error("unexpected output item: out_byte %02h", rsp_tdata);
         fail_count++;
      end else begin
         e = link_bytes.pop_front();
         if (rsp_tdata !== e.value) begin
            $error("out_byte: expected %02h, got %02h", e.value, rsp_tdata);
            fail_count++;
         end
         if (rsp_tuser[0] !== e.is_command) begin
            $error("is_command: expected %0b, got %0b", e.is_command, rsp_tuser[0]);
            fail_count++;
         end
         if (rsp_tuser[1] !== e.glyph_end) begin
            $error("glyph_end: expected %0b, got %0b", e.glyph_end, rsp_tuser[1]);
            fail_count++;
         end
         if (rsp_tlast !== e.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", e.last_of_run, rsp_tlast);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fg_color   = FG_RESET;
         bg_color   = BG_RESET;
         drawing    = 1'b0;
         cur_width  = '0;
         cur_height = '0;
         byte_col   = '0;
         row_cnt    = '0;
         link_bytes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_link_byte();
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FOREGROUND: fg_color = csr_data;
               CSR_BACKGROUND: bg_color = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expand_glyph_item(req_tuser[0], req_tdata);
      end
      pending    <= link_bytes.size();
      mismatches <= fail_count;
   end

endmodule

@@ test/tb.sv @@
// Testbench top: drives glyph starts, bitmap bytes and color writes into the core.
module tb
   import gbrs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_FOREGROUND;
   logic [COLOR_W-1:0]     csr_data   = '0;

   int mismatches;
   int pending;
   int items_sent = 0;
   bit calm       = 1'b0;
   int stall_asks = 0;
   int stall_seen = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   glyph_bitmap_to_rgb565_stream_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   glyph_stream_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // receiver: random backpressure, always ready when calm, or a long hold-off when asked
   always @(posedge clock) begin
      if (stall_asks != stall_seen) begin
         stall_seen = stall_asks;
         stall_left = 300;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 20);
      end
   end

   task automatic send_item(input mode_type mode, input logic [15:0] x, input logic [15:0] y,
                            input logic [6:0] w, input logic [6:0] h, input logic [7:0] bits);
      while (!calm && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, bits, h, w, y, x};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_bitmap(input logic [7:0] bits);
      send_item(MODE_BITMAP, 16'($urandom), 16'($urandom), 7'($urandom), 7'($urandom), bits);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_color(input csr_index_type idx, input logic [COLOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_bits();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return 8'h00;
      if (r < 20)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic random_glyph();
      int r;
      int w;
      int h;
      int wc;
      int hc;
      int nbytes;
      r = $urandom_range(99);
      if (r < 5)
         w = 0;
      else if (r < 15)
         w = $urandom_range(65, 127);
      else if (r < 25)
         w = $urandom_range(17, 64);
      else
         w = $urandom_range(1, 16);
      wc = (w > 64) ? 64 : w;
      r = $urandom_range(99);
      if (r < 5)
         h = 0;
      else if (r < 12 && wc >= 1 && wc <= 8)
         h = $urandom_range(17, 127);
      else if (wc > 16)
         h = $urandom_range(1, 3);
      else
         h = $urandom_range(1, 8);
      hc = (h > 64) ? 64 : h;
      nbytes = ((wc + 7) / 8) * hc;
      r = $urandom_range(99);
      if (r < 8)
         nbytes = $urandom_range(0, nbytes);
      else if (r < 14)
         nbytes = nbytes + $urandom_range(1, 3);
      if ($urandom_range(99) < 8)
         send_bitmap(pick_bits());
      send_item(MODE_START, 16'($urandom), 16'($urandom), 7'(w), 7'(h), 8'($urandom));
      for (int i = 0; i < nbytes; i++)
         send_bitmap(pick_bits());
   endtask

   task automatic random_phase(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target)
         random_glyph();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset colors
      send_item(MODE_BITMAP, 16'hFFFF, 16'hFFFF, 7'h7F, 7'h7F, 8'hFF);
      send_item(MODE_START, 16'h0000, 16'h0000, 7'd8, 7'd2, 8'h00);
      send_bitmap(8'hFF);
      send_bitmap(8'h00);
      send_item(MODE_START, 16'hFFFF, 16'hFFFF, 7'd64, 7'd1, 8'hFF);
      for (int i = 0; i < 8; i++)
         send_bitmap(8'(8'h5A + i * 8'h11));
      send_item(MODE_START, 16'd100, 16'd200, 7'd3, 7'd2, 8'h00);
      send_bitmap(8'hFF);
      send_bitmap(8'hFD);
      send_item(MODE_START, 16'h8000, 16'h7FFF, 7'h7F, 7'd0, 8'h00);
      send_bitmap(8'h3C);
      send_item(MODE_START, 16'h1234, 16'hABCD, 7'd0, 7'h7F, 8'h00);
      send_item(MODE_START, 16'd10, 16'd20, 7'd9, 7'd1, 8'h00);
      send_bitmap(8'h01);
      send_item(MODE_START, 16'h1234, 16'hABCD, 7'd1, 7'd1, 8'h00);
      send_bitmap(8'h01);
      drain();

      write_color(CSR_FOREGROUND, 16'h0000);
      write_color(CSR_BACKGROUND, 16'hFFFF);
      // long receiver hold-off while a full glyph is offered back to back
      calm       <= 1'b1;
      stall_asks <= stall_asks + 1;
      send_item(MODE_START, 16'($urandom), 16'($urandom), 7'd16, 7'd6, 8'h00);
      for (int i = 0; i < 12; i++)
         send_bitmap(pick_bits());
      calm <= 1'b0;
      random_phase(60);
      drain();

      write_color(CSR_FOREGROUND, 16'($urandom));
      write_color(CSR_BACKGROUND, 16'($urandom));
      calm <= 1'b1;
      random_phase(60);
      drain();

      calm <= 1'b0;
      write_color(CSR_FOREGROUND, 16'hF81F);
      write_color(CSR_BACKGROUND, 16'h07E0);
      random_phase(60);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
